// ===== src/mtda_pkg.sv =====
// ----------------------------------------------------------------------------
// mtda_pkg - shared types and constants for the milli-to-decimal ASCII core
// Holds the sequencer state type, the field widths and the ASCII codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mtda_pkg;

  localparam int VAL_W       = 32;  // input value width
  localparam int CHAR_W      = 8;   // one ASCII character
  localparam int DIG_W       = 4;   // one BCD digit
  localparam int BCD_DIGITS  = 10;  // enough for a 32-bit magnitude
  localparam int BCD_W       = BCD_DIGITS * DIG_W;
  localparam int INT_DIGITS  = 7;   // integer digits after dividing by 1000
  localparam int FRAC_DIGITS = 3;   // thousandths
  localparam int CNT_W       = 5;   // holds VAL_W - 1

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] ASCII_POINT = 8'h2E;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_INT,
    ST_POINT,
    ST_FRAC
  } state_t;

endpackage

`default_nettype wire

// ===== src/milli_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// milli_to_decimal_ascii_core - signed thousandths to decimal ASCII text
// Converts one signed 32-bit value by shift-and-add-3 into BCD, then emits
// the sign, integer digits, point and trimmed fraction one character at a time.
// ----------------------------------------------------------------------------
//
//  Channel | Ports       | tdata (low bit up)   | tuser | tlast
//  --------+-------------+----------------------+-------+----------------------
//  input   | in_t*       | value[31:0] (signed) | -     | -
//  result  | out_t*      | out_char[7:0]        | -     | final character
//
//  Sequence: each item is accepted, then converted one input bit a cycle
//  through the shared add-3/shift unit, then emits the sign when negative,
//  7 integer-digit steps, the point and 1 to 3 fraction steps. Leading
//  zeros take an integer-digit step each but emit no item.
//  Reset: rst_n, synchronous, active low; clears the sequencer and out_tvalid.
//  Stalls: out_tready low holds the current character and halts emission;
//  in_tready is high only while the sequencer is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module milli_to_decimal_ascii_core
  import mtda_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [VAL_W-1:0]  in_tdata,    // [31:0] value (signed)

  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [CHAR_W-1:0]      out_tdata,   // [7:0] out_char
  output logic                   out_tlast
);

  state_t               state_r,     state_nxt;
  logic [CNT_W-1:0]     cnt_r,       cnt_nxt;
  logic                 neg_r,       neg_nxt;
  logic                 started_r,   started_nxt;
  logic [VAL_W-1:0]     bin_r,       bin_nxt;
  logic [BCD_W-1:0]     bcd_r,       bcd_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r,  out_char_nxt;
  logic                 out_last_r,  out_last_nxt;

  logic [BCD_W-1:0]     bcd_adj;
  logic [DIG_W-1:0]     top_digit;
  logic [CHAR_W-1:0]    top_char;
  logic                 can_load;
  logic                 emit_int;
  logic                 frac_last;

  // Shared add-3 unit: correct every BCD digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[i*DIG_W +: DIG_W] >= DIG_W'(5)) begin
        bcd_adj[i*DIG_W +: DIG_W] = bcd_r[i*DIG_W +: DIG_W] + DIG_W'(3);
      end else begin
        bcd_adj[i*DIG_W +: DIG_W] = bcd_r[i*DIG_W +: DIG_W];
      end
    end
  end

  // The digit to print always sits at the top of the BCD register.
  assign top_digit = bcd_r[BCD_W-1 -: DIG_W];
  assign top_char  = ASCII_ZERO + {{(CHAR_W-DIG_W){1'b0}}, top_digit};
  assign can_load  = !out_valid_r || out_tready;

  // Print an integer digit once one was printed, or if non-zero, or if units.
  assign emit_int  = (top_digit != '0) || started_r || (cnt_r == CNT_W'(INT_DIGITS-1));

  // Drop trailing zeros after the first fraction digit.
  always_comb begin
    unique case (cnt_r)
      CNT_W'(0): frac_last = (bcd_r[BCD_W-DIG_W-1 -: 2*DIG_W] == '0);
      CNT_W'(1): frac_last = (bcd_r[BCD_W-DIG_W-1 -: DIG_W] == '0);
      default:   frac_last = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    started_nxt   = started_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          neg_nxt   = in_tdata[VAL_W-1];
          // Most negative value wraps to its unsigned magnitude here.
          bin_nxt   = in_tdata[VAL_W-1] ? (~in_tdata + VAL_W'(1)) : in_tdata;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end

      ST_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VAL_W-1]};
        bin_nxt = {bin_r[VAL_W-2:0], 1'b0};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(VAL_W-1)) begin
          // Last shift: the upper seven digits now hold the integer part.
          cnt_nxt     = '0;
          started_nxt = 1'b0;
          state_nxt   = neg_r ? ST_SIGN : ST_INT;
        end
      end

      ST_SIGN: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_INT;
        end
      end

      ST_INT: begin
        // Walk the seven integer digits from the top; skip leading zeros
        // without spending an item, but always print the units digit.
        if (!emit_int || can_load) begin
          if (emit_int) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = top_char;
            out_last_nxt  = 1'b0;
            started_nxt   = 1'b1;
          end
          bcd_nxt = {bcd_r[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(INT_DIGITS-1)) begin
            state_nxt = ST_POINT;
          end
        end
      end

      ST_POINT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_POINT;
          out_last_nxt  = 1'b0;
          cnt_nxt       = '0;
          state_nxt     = ST_FRAC;
        end
      end

      ST_FRAC: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = top_char;
          out_last_nxt  = frac_last;
          bcd_nxt       = {bcd_r[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
          cnt_nxt       = cnt_r + CNT_W'(1);
          if (frac_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
